### hw/rtl/svf_pkg.sv
// Shared types and constants for the spiral vector field pixel block.
package svf_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_RADIUS_SQ = 3'd2,
    REG_ROT_COS   = 3'd3,
    REG_ROT_SIN   = 3'd4,
    REG_HALF_EPS  = 3'd5
  } reg_idx_e;

  localparam int unsigned CfgW = 30;  // widest register
  localparam int unsigned SqW  = 28;  // square of one offset component
  localparam int unsigned N2W  = 29;  // squared offset length
  localparam int unsigned QW   = 15;  // unit component magnitude search width
  localparam int unsigned VW   = 16;  // Q2.14 vector component

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [13:0]        center_x;
    logic [13:0]        center_y;
    logic [29:0]        radius_sq;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
    logic [14:0]        half_eps;
  } cfg_t;

  // One classified pixel passed from the front to the back.
  typedef struct packed {
    logic           sign_x;
    logic           sign_y;
    logic [SqW-1:0] sq_x;
    logic [SqW-1:0] sq_y;
    logic [N2W-1:0] n2;
    logic           outside;
    logic           degenerate;
  } mid_t;

  // One finished result.
  typedef struct packed {
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic                 outside;
    logic                 degenerate;
  } res_t;

endpackage

### hw/rtl/svf_fifo.sv
// Small register-based FIFO used between pipeline sections and as the result queue.
module svf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointer and count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/svf_front.sv
// Front section: takes pixels, forms offsets and squared length, classifies.
module svf_front #(
  parameter int unsigned GRID_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [9:0]    pixel_x_i,
  input  logic [9:0]    pixel_y_i,
  input  svf_pkg::cfg_t cfg_i,
  output logic          mid_push_o,
  output svf_pkg::mid_t mid_o,
  input  logic          mid_full_i
);

  localparam logic [9:0] GridMask =
    (GRID_BITS >= 10) ? 10'h3FF : 10'((32'd1 << GRID_BITS) - 32'd1);

  logic                     en;
  logic                     v1_q, v2_q, v3_q;
  logic signed [14:0]       dx_q, dy_q;
  logic signed [14:0]       dx_d, dy_d;
  logic [13:0]              ax, ay;
  logic [svf_pkg::SqW-1:0]  sqx_q, sqy_q;
  logic                     sgx_q, sgy_q;
  logic [svf_pkg::N2W-1:0]  n2;
  svf_pkg::mid_t            mid_q;

  // The whole front advances unless its last stage is blocked.
  assign en         = !(v3_q && mid_full_i);
  assign full_o     = !en;
  assign mid_push_o = v3_q && !mid_full_i;
  assign mid_o      = mid_q;

  // Offset from center in Q11.4.
  assign dx_d = $signed({1'b0, pixel_x_i & GridMask, 4'b0000}) - $signed({1'b0, cfg_i.center_x});
  assign dy_d = $signed({1'b0, pixel_y_i & GridMask, 4'b0000}) - $signed({1'b0, cfg_i.center_y});

  // Magnitudes for squaring.
  assign ax = dx_q[14] ? 14'(-dx_q) : dx_q[13:0];
  assign ay = dy_q[14] ? 14'(-dy_q) : dy_q[13:0];

  assign n2 = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q             <= dx_d;
      dy_q             <= dy_d;
      sqx_q            <= ax * ax;
      sqy_q            <= ay * ay;
      sgx_q            <= dx_q[14];
      sgy_q            <= dy_q[14];
      mid_q.sign_x     <= sgx_q;
      mid_q.sign_y     <= sgy_q;
      mid_q.sq_x       <= sqx_q;
      mid_q.sq_y       <= sqy_q;
      mid_q.n2         <= n2;
      mid_q.outside    <= ({1'b0, n2} > cfg_i.radius_sq);
      mid_q.degenerate <= (n2 == '0);
    end
  end

endmodule

### hw/rtl/svf_back.sv
// Back section: bitwise unit-vector search, rotation and outer snap.
module svf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  svf_pkg::cfg_t cfg_i,
  input  svf_pkg::mid_t mid_i,
  input  logic          mid_empty_i,
  output logic          mid_pop_o,
  output logic          out_push_o,
  output svf_pkg::res_t res_o,
  input  logic          out_full_i
);

  localparam int unsigned QW = svf_pkg::QW;
  localparam int unsigned RW = 60;
  localparam int unsigned TW = 45;

  typedef struct packed {
    logic [QW-1:0]           qx;
    logic [QW-1:0]           qy;
    logic [RW-1:0]           rx;
    logic [RW-1:0]           ry;
    logic [svf_pkg::N2W-1:0] n2;
    logic                    sx;
    logic                    sy;
    logic                    outside;
    logic                    degenerate;
  } root_t;

  typedef struct packed {
    logic outside;
    logic degenerate;
  } flag_t;

  logic          en;
  root_t         init;
  root_t         last;
  logic          last_v;

  logic                 rot_v_q, sum_v_q, div_v_q, res_v_q;
  logic signed [15:0]   ux, uy;
  logic signed [31:0]   pxc_q, pys_q, pxs_q, pyc_q;
  flag_t                rot_f_q, sum_f_q, div_f_q;
  logic signed [32:0]   sx_q, sy_q;
  logic signed [32:0]   sx_adj, sy_adj;
  logic signed [18:0]   qx_div, qy_div;
  logic signed [15:0]   vx_q, vy_q, vx_sat, vy_sat;
  logic [15:0]          avx, avy;
  logic signed [15:0]   e;
  svf_pkg::res_t        res_d, res_q;

  // The back stalls as a whole only when a finished result cannot leave.
  assign en         = !(res_v_q && out_full_i);
  assign mid_pop_o  = en && !mid_empty_i;
  assign out_push_o = res_v_q && !out_full_i;
  assign res_o      = res_q;

  // Search start: remainder is a^2 * 2^28.
  always_comb begin
    init.qx         = '0;
    init.qy         = '0;
    init.rx         = {4'b0000, mid_i.sq_x, 28'd0};
    init.ry         = {4'b0000, mid_i.sq_y, 28'd0};
    init.n2         = mid_i.n2;
    init.sx         = mid_i.sign_x;
    init.sy         = mid_i.sign_y;
    init.outside    = mid_i.outside;
    init.degenerate = mid_i.degenerate;
  end

  // One result bit per pair of stages: multiply, then compare and subtract.
  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int unsigned K = QW - 1 - i;
    localparam logic [QW:0] Bit = (QW + 1)'(1) << K;
    root_t         src;
    logic          src_v;
    root_t         mul_q, cmp_d, cmp_q;
    logic          mul_v_q, cmp_v_q;
    logic [TW-1:0] tx_q, ty_q;
    logic [RW-1:0] shx, shy;

    if (i == 0) begin : g_first
      assign src   = init;
      assign src_v = mid_pop_o;
    end else begin : g_rest
      assign src   = g_bit[i-1].cmp_q;
      assign src_v = g_bit[i-1].cmp_v_q;
    end

    assign shx = RW'(tx_q) << K;
    assign shy = RW'(ty_q) << K;

    // Keep the bit where the trial step still fits in the remainder.
    always_comb begin
      cmp_d = mul_q;
      if (shx <= mul_q.rx) begin
        cmp_d.rx = mul_q.rx - shx;
        cmp_d.qx = mul_q.qx | QW'(Bit);
      end
      if (shy <= mul_q.ry) begin
        cmp_d.ry = mul_q.ry - shy;
        cmp_d.qy = mul_q.qy | QW'(Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_v_q <= 1'b0;
        cmp_v_q <= 1'b0;
      end else if (en) begin
        mul_v_q <= src_v;
        cmp_v_q <= mul_v_q;
      end
    end

    // Trial step (2q + 2^k) * n2; its shift by k is what q^2 n2 grows by.
    always_ff @(posedge clk_i) begin
      if (en) begin
        mul_q <= src;
        tx_q  <= TW'({src.qx, 1'b0} | Bit) * TW'(src.n2);
        ty_q  <= TW'({src.qy, 1'b0} | Bit) * TW'(src.n2);
        cmp_q <= cmp_d;
      end
    end
  end

  assign last   = g_bit[QW-1].cmp_q;
  assign last_v = g_bit[QW-1].cmp_v_q;

  // Signed unit components.
  assign ux = last.sx ? -$signed({1'b0, last.qx}) : $signed({1'b0, last.qx});
  assign uy = last.sy ? -$signed({1'b0, last.qy}) : $signed({1'b0, last.qy});

  // Truncating division by 2^14 toward zero, then saturation.
  assign sx_adj = sx_q[32] ? sx_q + 33'sd16383 : sx_q;
  assign sy_adj = sy_q[32] ? sy_q + 33'sd16383 : sy_q;
  assign qx_div = 19'(sx_adj >>> 14);
  assign qy_div = 19'(sy_adj >>> 14);
  assign vx_sat = (qx_div > 19'sd32767) ? 16'sh7FFF :
                  (qx_div < -19'sd32768) ? 16'sh8000 : 16'(qx_div);
  assign vy_sat = (qy_div > 19'sd32767) ? 16'sh7FFF :
                  (qy_div < -19'sd32768) ? 16'sh8000 : 16'(qy_div);

  // Outer snap to the nearest axis; exact diagonals turn counterclockwise.
  assign avx = vx_q[15] ? 16'(-vx_q) : vx_q;
  assign avy = vy_q[15] ? 16'(-vy_q) : vy_q;
  assign e   = $signed({1'b0, cfg_i.half_eps});

  always_comb begin
    res_d.vec_x      = vx_q;
    res_d.vec_y      = vy_q;
    res_d.outside    = div_f_q.outside;
    res_d.degenerate = div_f_q.degenerate;
    if (div_f_q.degenerate) begin
      res_d.vec_x   = '0;
      res_d.vec_y   = '0;
      res_d.outside = 1'b0;
    end else if (div_f_q.outside) begin
      res_d.vec_x = '0;
      res_d.vec_y = '0;
      if (avx == '0 && avy == '0) begin
        res_d.vec_x = e;
      end else if (avx > avy) begin
        res_d.vec_x = (vx_q > 0) ? e : -e;
      end else if (avy > avx) begin
        res_d.vec_y = (vy_q > 0) ? e : -e;
      end else if (vx_q > 0 && vy_q > 0) begin
        res_d.vec_y = e;
      end else if (vx_q < 0 && vy_q > 0) begin
        res_d.vec_x = -e;
      end else if (vx_q < 0 && vy_q < 0) begin
        res_d.vec_y = -e;
      end else begin
        res_d.vec_x = e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_v_q <= 1'b0;
      sum_v_q <= 1'b0;
      div_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else if (en) begin
      rot_v_q <= last_v;
      sum_v_q <= rot_v_q;
      div_v_q <= sum_v_q;
      res_v_q <= div_v_q;
    end
  end

  // Rotation products, sums, scaling and snap.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxc_q   <= ux * cfg_i.rot_cos;
      pys_q   <= uy * cfg_i.rot_sin;
      pxs_q   <= ux * cfg_i.rot_sin;
      pyc_q   <= uy * cfg_i.rot_cos;
      rot_f_q <= '{outside: last.outside, degenerate: last.degenerate};
      sx_q    <= 33'(pxc_q) - 33'(pys_q);
      sy_q    <= 33'(pxs_q) + 33'(pyc_q);
      sum_f_q <= rot_f_q;
      vx_q    <= vx_sat;
      vy_q    <= vy_sat;
      div_f_q <= sum_f_q;
      res_q   <= res_d;
    end
  end

endmodule

### hw/rtl/spiral_vector_field_pixel.sv
// Top level of the spiral vector field pixel block.
//
//   Channel   Handshake             Payload
//   input     push / full           pixel_x_i, pixel_y_i
//   result    empty / pop           vec_x_o, vec_y_o, outside_o, degenerate_o
//   config    cfg_we_i              cfg_idx_i, cfg_data_i
//
// One pixel is taken every cycle while full is low; each result appears after its
// transfer in has passed 3 front stages, a 4-entry queue, 30 search stages of the
// unit vector, 4 rotation and snap stages and the output queue.
// Most of the path is the unit-vector search, one result bit per two stages.
// Reset clears control state and loads the register reset values.
// A stalled result side backs up the back section, then the middle queue,
// then the front, which raises full.
module spiral_vector_field_pixel #(
  parameter int unsigned GRID_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [9:0]         pixel_x_i,
  input  logic [9:0]         pixel_y_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] vec_x_o,
  output logic signed [15:0] vec_y_o,
  output logic               outside_o,
  output logic               degenerate_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [29:0]        cfg_data_i
);

  svf_pkg::cfg_t cfg_q;
  svf_pkg::mid_t mid_in, mid_out;
  svf_pkg::res_t res_in, res_out;
  logic          mid_push, mid_full, mid_pop, mid_empty;
  logic          out_push, out_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x  <= '0;
      cfg_q.center_y  <= '0;
      cfg_q.radius_sq <= '0;
      cfg_q.rot_cos   <= 16'sd16384;
      cfg_q.rot_sin   <= '0;
      cfg_q.half_eps  <= '0;
    end else if (cfg_we_i) begin
      case (svf_pkg::reg_idx_e'(cfg_idx_i))
        svf_pkg::REG_CENTER_X:  cfg_q.center_x  <= cfg_data_i[13:0];
        svf_pkg::REG_CENTER_Y:  cfg_q.center_y  <= cfg_data_i[13:0];
        svf_pkg::REG_RADIUS_SQ: cfg_q.radius_sq <= cfg_data_i;
        svf_pkg::REG_ROT_COS:   cfg_q.rot_cos   <= cfg_data_i[15:0];
        svf_pkg::REG_ROT_SIN:   cfg_q.rot_sin   <= cfg_data_i[15:0];
        svf_pkg::REG_HALF_EPS:  cfg_q.half_eps  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Front: offsets, squared length, classification.
  svf_front #(.GRID_BITS(GRID_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .cfg_i      (cfg_q),
    .mid_push_o (mid_push),
    .mid_o      (mid_in),
    .mid_full_i (mid_full)
  );

  // Queue between front and back.
  svf_fifo #(.WIDTH($bits(svf_pkg::mid_t)), .DEPTH(4)) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // Back: unit vector, rotation, snap.
  svf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_i       (mid_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .res_o       (res_in),
    .out_full_i  (out_full)
  );

  // Result queue.
  svf_fifo #(.WIDTH($bits(svf_pkg::res_t)), .DEPTH(4)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign vec_x_o      = res_out.vec_x;
  assign vec_y_o      = res_out.vec_y;
  assign outside_o    = res_out.outside;
  assign degenerate_o = res_out.degenerate;

  // A pixel at the center gives a zero vector that is never snapped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && degenerate_o) |-> (vec_x_o == 16'sd0 && vec_y_o == 16'sd0 && !outside_o))
    else $error("degenerate result carries a nonzero vector or outside flag");

  // A snapped vector lies on one axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && outside_o) |-> (vec_x_o == 16'sd0 || vec_y_o == 16'sd0))
    else $error("outside result is not on an axis");

  // The back never pushes into a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |-> !out_push)
    else $error("push into full result queue");

endmodule

### sim/testbench.sv
// Testbench for the spiral vector field pixel block: directed, random and back-pressure pixel runs.
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY    = 40;
  localparam int CYCLE_CAP  = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [9:0]         pixel_x_i = '0;
  logic [9:0]         pixel_y_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] vec_x_o;
  logic signed [15:0] vec_y_o;
  logic               outside_o;
  logic               degenerate_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [29:0]        cfg_data_i = '0;

  spiral_vector_field_pixel dut (
    .clk_i, .rst_ni, .push, .full, .pixel_x_i, .pixel_y_i, .empty, .pop,
    .vec_x_o, .vec_y_o, .outside_o, .degenerate_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic [13:0]       m_cx, m_cy;
  logic [29:0]       m_r2;
  logic signed [15:0] m_cos, m_sin;
  logic [14:0]       m_eps;

  svf_pkg::res_t pending_vecs[$];
  int     errors = 0;
  int     sent = 0;
  int     checked = 0;
  int     outside_seen = 0;
  int     degen_seen = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  bit     hold_recv = 1'b0;
  longint cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // Largest q in 0..16384 with q*q*n2 <= a*a*2^28, carrying the sign of a.
  function automatic longint unit_part(longint a, longint n2);
    longint aa, lim, lo, hi, mid;
    aa = a < 0 ? -a : a;
    lim = (aa * aa) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) >>> 1;
      if (mid * mid * n2 <= lim) lo = mid;
      else hi = mid - 1;
    end
    return a < 0 ? -lo : lo;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic svf_pkg::res_t field_vector(logic [9:0] px, logic [9:0] py);
    svf_pkg::res_t r;
    longint dx, dy, n2, ux, uy, vx, vy, ax, ay, e, c, s;
    dx = longint'(px) * 16 - longint'(m_cx);
    dy = longint'(py) * 16 - longint'(m_cy);
    n2 = dx * dx + dy * dy;
    vx = 0;
    vy = 0;
    r.outside = 1'b0;
    r.degenerate = 1'b0;
    if (n2 == 0) begin
      r.degenerate = 1'b1;
    end else begin
      c = longint'(m_cos);
      s = longint'(m_sin);
      ux = unit_part(dx, n2);
      uy = unit_part(dy, n2);
      vx = clip16((ux * c - uy * s) / 16384);
      vy = clip16((ux * s + uy * c) / 16384);
      if (n2 > longint'(m_r2)) begin
        ax = vx < 0 ? -vx : vx;
        ay = vy < 0 ? -vy : vy;
        e = longint'(m_eps);
        r.outside = 1'b1;
        if (ax == 0 && ay == 0) begin vx = e; vy = 0; end
        else if (ax > ay) begin vx = vx > 0 ? e : -e; vy = 0; end
        else if (ay > ax) begin vx = 0; vy = vy > 0 ? e : -e; end
        // Exact diagonal turns counterclockwise.
        else if (vx > 0 && vy > 0) begin vx = 0; vy = e; end
        else if (vx < 0 && vy > 0) begin vx = -e; vy = 0; end
        else if (vx < 0 && vy < 0) begin vx = 0; vy = -e; end
        else begin vx = e; vy = 0; end
      end
    end
    r.vec_x = vx[15:0];
    r.vec_y = vy[15:0];
    return r;
  endfunction

  // Write one register; the caller drops the write enable after its last write.
  task automatic write_reg(input svf_pkg::reg_idx_e idx, input logic [29:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      svf_pkg::REG_CENTER_X:  m_cx = val[13:0];
      svf_pkg::REG_CENTER_Y:  m_cy = val[13:0];
      svf_pkg::REG_RADIUS_SQ: m_r2 = val;
      svf_pkg::REG_ROT_COS:   m_cos = val[15:0];
      svf_pkg::REG_ROT_SIN:   m_sin = val[15:0];
      svf_pkg::REG_HALF_EPS:  m_eps = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [13:0] cx, input logic [13:0] cy,
                            input logic [29:0] r2, input logic [15:0] c,
                            input logic [15:0] s, input logic [14:0] e);
    write_reg(svf_pkg::REG_CENTER_X, 30'(cx));
    write_reg(svf_pkg::REG_CENTER_Y, 30'(cy));
    write_reg(svf_pkg::REG_RADIUS_SQ, r2);
    write_reg(svf_pkg::REG_ROT_COS, 30'(c));
    write_reg(svf_pkg::REG_ROT_SIN, 30'(s));
    write_reg(svf_pkg::REG_HALF_EPS, 30'(e));
    cfg_we_i <= 1'b0;
  endtask

  // Offer one pixel, optionally idling first, and hold it until the transfer.
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_vecs.push_back(field_vector(px, py));
    sent++;
  endtask

  task automatic drain;
    int n;
    n = 0;
    push <= 1'b0;
    while (pending_vecs.size() != 0) @(posedge clk_i);
    while (n < LATENCY + 5) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  // Receiver: random stalls, or a long hold when the pressure test asks.
  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= !hold_recv && ($urandom_range(99) >= recv_stall);
  end

  // Result checker.
  always @(posedge clk_i) begin
    svf_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_vecs.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_vecs.pop_front();
        checked++;
        if (want.outside) outside_seen++;
        if (want.degenerate) degen_seen++;
        if (vec_x_o !== want.vec_x)
          report($sformatf("vec_x got %0d want %0d", vec_x_o, want.vec_x));
        if (vec_y_o !== want.vec_y)
          report($sformatf("vec_y got %0d want %0d", vec_y_o, want.vec_y));
        if (outside_o !== want.outside)
          report($sformatf("outside got %b want %b", outside_o, want.outside));
        if (degenerate_o !== want.degenerate)
          report($sformatf("degenerate got %b want %b", degenerate_o, want.degenerate));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL spiral_vector_field_pixel");
      $finish;
    end
  end

  task automatic test_reset_values;
    m_cx = 0; m_cy = 0; m_r2 = 0; m_cos = 16384; m_sin = 0; m_eps = 0;
    // Origin equals center after reset; the others land outside with zero magnitude.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd5, 10'd0);
    drain();
  endtask

  task automatic test_directed;
    // Inside with identity rotation, extremes of both fields, center hit.
    set_config(14'd8000, 14'd8000, 30'h3FFF_FFFF, 16'sd16384, 16'sd0, 15'd32767);
    send_pixel(10'd500, 10'd500);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd700, 10'd300);
    drain();
    // Outside with diagonals in each quadrant and axis directions.
    set_config(14'd8000, 14'd8000, 30'd0, 16'sd16384, 16'sd0, 15'd32767);
    send_pixel(10'd510, 10'd510);
    send_pixel(10'd490, 10'd510);
    send_pixel(10'd490, 10'd490);
    send_pixel(10'd510, 10'd490);
    send_pixel(10'd520, 10'd505);
    send_pixel(10'd505, 10'd480);
    send_pixel(10'd500, 10'd500);
    drain();
    // Zero rotation outside and inside, then saturating rotation.
    set_config(14'd16383, 14'd0, 30'd1000, 16'sd0, 16'sd0, 15'd1234);
    send_pixel(10'd1023, 10'd1);
    send_pixel(10'd3, 10'd9);
    drain();
    set_config(14'd16383, 14'd16383, 30'h3FFF_FFFF, 16'h7FFF, 16'h8000, 15'd100);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd200, 10'd900);
    drain();
  endtask

  task automatic random_config;
    logic [29:0] r2;
    int sel;
    sel = $urandom_range(3);
    r2 = sel == 0 ? 30'd0 : sel == 1 ? 30'h3FFF_FFFF : 30'($urandom_range(0, 30'h3FFF_FFFF));
    if (sel == 3) r2 = 30'($urandom_range(0, 30'h00FF_FFFF));
    set_config(14'($urandom), 14'($urandom), r2,
               $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384),
               $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384),
               15'($urandom));
  endtask

  task automatic random_phase(input int idle, input int stall, input int count);
    logic [13:0] c;
    send_idle = idle;
    recv_stall = stall;
    random_config();
    repeat (count) begin
      // Mostly pixels near the center so the radius boundary is exercised.
      if ($urandom_range(3) == 0) begin
        send_pixel(10'($urandom), 10'($urandom));
      end else begin
        c = m_cx;
        send_pixel(10'((c >> 4) + $urandom_range(0, 16) - 8),
                   10'((m_cy >> 4) + $urandom_range(0, 16) - 8));
      end
    end
    drain();
  endtask

  task automatic test_random;
    repeat (4) random_phase(0, 0, 40);
    repeat (4) random_phase(47, 0, 40);
    repeat (4) random_phase(0, 47, 40);
    repeat (4) random_phase(34, 34, 40);
  endtask

  task automatic test_backpressure;
    int held;
    send_idle = 0;
    recv_stall = 0;
    random_config();
    hold_recv = 1'b1;
    fork
      begin
        held = 0;
        while (held < 300) begin
          @(posedge clk_i);
          held++;
        end
        hold_recv = 1'b0;
      end
      repeat (80) send_pixel(10'($urandom), 10'($urandom));
    join
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_random();
    test_backpressure();
    $display("Sent %0d pixels over %0d cycles, checked %0d results.", sent, cycles, checked);
    $display("Outer snapped results: %0d, center hits: %0d.", outside_seen, degen_seen);
    if (errors == 0 && pending_vecs.size() == 0) begin
      $display("PASS spiral_vector_field_pixel");
    end else begin
      $display("FAIL spiral_vector_field_pixel");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/svf_pkg.sv
hw/rtl/svf_fifo.sv
hw/rtl/svf_front.sv
hw/rtl/svf_back.sv
hw/rtl/spiral_vector_field_pixel.sv
sim/testbench.sv
